[hw/rtl/x86alu_pkg.sv]
// ----------------------------------------------------------------------------
// x86alu_pkg
// Shared types and constants for the 16-bit x86 ALU and register file.
// ----------------------------------------------------------------------------
package x86alu_pkg;

    // Register file: eight general words, then four segment words
    localparam int unsigned GenCount  = 8;
    localparam int unsigned SegCount  = 4;
    localparam int unsigned RegCount  = GenCount + SegCount;
    localparam int unsigned WordWidth = 16;
    localparam int unsigned AddrWidth = $clog2(RegCount);

    localparam logic [WordWidth-1:0] SignWord = 16'h8000;
    localparam logic [WordWidth-1:0] SignByte = 16'h0080;

    // Operation codes; codes 9 to 15 are undefined and do nothing
    typedef enum logic [3:0] {
        MODE_ADD = 4'd0,
        MODE_OR  = 4'd1,
        MODE_ADC = 4'd2,
        MODE_SBB = 4'd3,
        MODE_AND = 4'd4,
        MODE_SUB = 4'd5,
        MODE_XOR = 4'd6,
        MODE_CMP = 4'd7,
        MODE_MOV = 4'd8
    } mode_t;

    // Status flags
    typedef struct packed {
        logic o;
        logic s;
        logic z;
        logic a;
        logic p;
        logic c;
    } flags_t;

    // Register file address of an operand or destination word
    function automatic logic [AddrWidth-1:0] reg_addr(input logic [2:0] idx,
                                                      input logic       seg,
                                                      input logic       wide);
        logic [AddrWidth-1:0] addr;
        if (wide && seg)
        begin
            addr = AddrWidth'(GenCount) + AddrWidth'(idx[1:0]);
        end
        else if (wide)
        begin
            addr = AddrWidth'(idx);
        end
        else
        begin
            addr = AddrWidth'(idx[1:0]);
        end
        return addr;
    endfunction

endpackage

[hw/rtl/x86alu_ram.sv]
// ----------------------------------------------------------------------------
// x86alu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module x86alu_ram #(
    parameter int unsigned Width = 16,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/x86alu_alu.sv]
// ----------------------------------------------------------------------------
// x86alu_alu
// Operation datapath: operand selection, result, flags and word merge.
// ----------------------------------------------------------------------------
module x86alu_alu import x86alu_pkg::*; (
    input  logic [3:0]           mode,
    input  logic                 is_wide,
    input  logic                 dst_high,
    input  logic                 src_high,
    input  logic                 src_is_immediate,
    input  logic [WordWidth-1:0] immediate_value,
    input  logic [WordWidth-1:0] dst_word,
    input  logic [WordWidth-1:0] src_word,
    input  flags_t               flags_in,
    output logic                 wr_en,
    output logic                 flags_en,
    output logic [WordWidth-1:0] word_out,
    output flags_t               flags_out
);

    logic [WordWidth-1:0] a;
    logic [WordWidth-1:0] b;
    logic [WordWidth-1:0] res;
    logic [WordWidth-1:0] sign_mask;
    logic [WordWidth:0]   add_sum;
    logic [WordWidth:0]   sub_dif;
    logic [WordWidth:0]   r;
    logic                 is_sub;

    // Operands at operand width; byte registers 4 to 7 are high halves
    always_comb
    begin
        if (is_wide)
        begin
            a = dst_word;
            b = src_is_immediate ? immediate_value : src_word;
        end
        else
        begin
            a = {8'h00, dst_high ? dst_word[15:8] : dst_word[7:0]};
            if (src_is_immediate)
            begin
                b = {8'h00, immediate_value[7:0]};
            end
            else
            begin
                b = {8'h00, src_high ? src_word[15:8] : src_word[7:0]};
            end
        end
    end

    assign add_sum   = {1'b0, a} + {1'b0, b};
    assign sub_dif   = {1'b0, a} - {1'b0, b};
    assign sign_mask = is_wide ? SignWord : SignByte;

    // Result select
    always_comb
    begin
        r        = '0;
        wr_en    = 1'b1;
        flags_en = 1'b0;
        is_sub   = 1'b0;
        unique case (mode_t'(mode))
            MODE_ADD:
            begin
                r        = add_sum;
                flags_en = 1'b1;
            end
            MODE_OR:  r = {1'b0, a | b};
            MODE_ADC: r = add_sum + (WordWidth+1)'(flags_in.c);
            MODE_SBB: r = sub_dif - (WordWidth+1)'(flags_in.c);
            MODE_AND: r = {1'b0, a & b};
            MODE_SUB:
            begin
                r        = sub_dif;
                flags_en = 1'b1;
                is_sub   = 1'b1;
            end
            MODE_XOR: r = {1'b0, a ^ b};
            MODE_CMP:
            begin
                r        = sub_dif;
                flags_en = 1'b1;
                is_sub   = 1'b1;
                wr_en    = 1'b0;
            end
            MODE_MOV: r = {1'b0, b};
            default:  wr_en = 1'b0;
        endcase
    end

    assign res = is_wide ? r[WordWidth-1:0] : {8'h00, r[7:0]};

    // Flags for ADD, SUB and CMP
    always_comb
    begin
        flags_out = flags_in;
        if (flags_en)
        begin
            if (is_sub)
            begin
                flags_out.c = sub_dif[WordWidth];
                flags_out.o = |((a ^ b) & (a ^ res) & sign_mask);
            end
            else
            begin
                flags_out.c = is_wide ? add_sum[WordWidth] : add_sum[8];
                flags_out.o = |((a ^ res) & (b ^ res) & sign_mask);
            end
            flags_out.a = a[4] ^ b[4] ^ res[4];
            flags_out.s = |(res & sign_mask);
            flags_out.z = (res == '0);
            flags_out.p = ~^res[7:0];
        end
    end

    // Merge result into the whole destination word
    always_comb
    begin
        if (!wr_en)
        begin
            word_out = dst_word;
        end
        else if (is_wide)
        begin
            word_out = res;
        end
        else if (dst_high)
        begin
            word_out = {res[7:0], dst_word[7:0]};
        end
        else
        begin
            word_out = {dst_word[15:8], res[7:0]};
        end
    end

endmodule

[hw/rtl/x86_16bit_alu_regfile_execute.sv]
// ----------------------------------------------------------------------------
// x86_16bit_alu_regfile_execute
// 16-bit x86 ALU with general and segment register file and status flags.
//
//  Channel | Handshake            | Word
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | mode, indexes, markers, immediate_value
//  out     | out_valid / out_ready| value_before, value_after, six flags
//
// One word per cycle sustained while out_ready holds; out_valid rises as the
// operate stage advances. The accepting edge reads both operand words from
// the RAMs; the operate stage then computes, writes back and loads the output register.
// A write at the edge where the next word is read is forwarded.
// Reset clears the entry valid bits and flags; unwritten entries read zero.
// A stalled output holds the operate stage, then in_ready drops.
// ----------------------------------------------------------------------------
module x86_16bit_alu_regfile_execute import x86alu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  mode,
    input  logic [2:0]  dst_index,
    input  logic        dst_is_segment,
    input  logic [2:0]  src_index,
    input  logic        src_is_segment,
    input  logic        src_is_immediate,
    input  logic        is_wide,
    input  logic [15:0] immediate_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] value_before,
    output logic [15:0] value_after,
    output logic        carry_flag,
    output logic        parity_flag,
    output logic        aux_flag,
    output logic        zero_flag,
    output logic        sign_flag,
    output logic        overflow_flag
);

    logic                 in_acc;
    logic [AddrWidth-1:0] rd_daddr;
    logic [AddrWidth-1:0] rd_saddr;

    // Operate stage
    logic                 s1_vld_reg;
    logic [3:0]           s1_mode_reg;
    logic                 s1_wide_reg;
    logic                 s1_dhigh_reg;
    logic                 s1_shigh_reg;
    logic                 s1_imm_sel_reg;
    logic [WordWidth-1:0] s1_imm_reg;
    logic [AddrWidth-1:0] s1_daddr_reg;
    logic [AddrWidth-1:0] s1_saddr_reg;
    logic                 s1_dvld_reg;
    logic                 s1_svld_reg;
    logic                 s1_adv;

    // Register file state
    logic [RegCount-1:0]  ent_vld_reg;
    logic                 fwd_vld_reg;
    logic [AddrWidth-1:0] fwd_addr_reg;
    logic [WordWidth-1:0] fwd_data_reg;
    flags_t               flags_reg;

    logic [WordWidth-1:0] ram_dword;
    logic [WordWidth-1:0] ram_sword;
    logic [WordWidth-1:0] dst_word;
    logic [WordWidth-1:0] src_word;
    logic                 wr_en;
    logic                 flags_en;
    logic                 wr_fire;
    logic [WordWidth-1:0] word_out;
    flags_t               flags_next;

    // Output register
    logic                 o_vld_reg;
    logic                 o_vld_next;
    logic [WordWidth-1:0] o_before_reg;
    logic [WordWidth-1:0] o_after_reg;
    flags_t               o_flags_reg;

    assign s1_adv   = s1_vld_reg && (!o_vld_reg || out_ready);
    assign in_ready = !s1_vld_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;
    assign rd_daddr = reg_addr(dst_index, dst_is_segment, is_wide);
    assign rd_saddr = reg_addr(src_index, src_is_segment, is_wide);
    assign wr_fire  = s1_adv && wr_en;

    // Two copies of the register file, one per operand read
    x86alu_ram #(
        .Width (WordWidth),
        .Depth (RegCount)
    ) u_ram_dst (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (s1_daddr_reg),
        .wdata (word_out),
        .re    (in_acc),
        .raddr (rd_daddr),
        .rdata (ram_dword)
    );

    x86alu_ram #(
        .Width (WordWidth),
        .Depth (RegCount)
    ) u_ram_src (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (s1_daddr_reg),
        .wdata (word_out),
        .re    (in_acc),
        .raddr (rd_saddr),
        .rdata (ram_sword)
    );

    // Operand words: forward the write that coincided with the read
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == s1_daddr_reg))
        begin
            dst_word = fwd_data_reg;
        end
        else
        begin
            dst_word = s1_dvld_reg ? ram_dword : '0;
        end
        if (fwd_vld_reg && (fwd_addr_reg == s1_saddr_reg))
        begin
            src_word = fwd_data_reg;
        end
        else
        begin
            src_word = s1_svld_reg ? ram_sword : '0;
        end
    end

    x86alu_alu u_alu (
        .mode             (s1_mode_reg),
        .is_wide          (s1_wide_reg),
        .dst_high         (s1_dhigh_reg),
        .src_high         (s1_shigh_reg),
        .src_is_immediate (s1_imm_sel_reg),
        .immediate_value  (s1_imm_reg),
        .dst_word         (dst_word),
        .src_word         (src_word),
        .flags_in         (flags_reg),
        .wr_en            (wr_en),
        .flags_en         (flags_en),
        .word_out         (word_out),
        .flags_out        (flags_next)
    );

    assign o_vld_next = s1_adv || (o_vld_reg && !out_ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            o_vld_reg   <= 1'b0;
            ent_vld_reg <= '0;
            fwd_vld_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end
            o_vld_reg <= o_vld_next;
            if (wr_fire)
            begin
                ent_vld_reg[s1_daddr_reg] <= 1'b1;
                fwd_vld_reg               <= 1'b1;
            end
            if (s1_adv && flags_en)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_mode_reg    <= mode;
            s1_wide_reg    <= is_wide;
            s1_dhigh_reg   <= !is_wide && dst_index[2];
            s1_shigh_reg   <= !is_wide && src_index[2];
            s1_imm_sel_reg <= src_is_immediate;
            s1_imm_reg     <= immediate_value;
            s1_daddr_reg   <= rd_daddr;
            s1_saddr_reg   <= rd_saddr;
            s1_dvld_reg    <= ent_vld_reg[rd_daddr];
            s1_svld_reg    <= ent_vld_reg[rd_saddr];
        end
        if (wr_fire)
        begin
            fwd_addr_reg <= s1_daddr_reg;
            fwd_data_reg <= word_out;
        end
        if (s1_adv)
        begin
            o_before_reg <= dst_word;
            o_after_reg  <= word_out;
            o_flags_reg  <= flags_en ? flags_next : flags_reg;
        end
    end

    assign out_valid     = o_vld_reg;
    assign value_before  = o_before_reg;
    assign value_after   = o_after_reg;
    assign carry_flag    = o_flags_reg.c;
    assign parity_flag   = o_flags_reg.p;
    assign aux_flag      = o_flags_reg.a;
    assign zero_flag     = o_flags_reg.z;
    assign sign_flag     = o_flags_reg.s;
    assign overflow_flag = o_flags_reg.o;

    // Checks
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire |-> (s1_daddr_reg < AddrWidth'(RegCount)))
        else $error("register file write beyond last entry");

    a_cmp_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && (s1_mode_reg == MODE_CMP)) |-> !wr_en)
        else $error("compare wrote its destination");

    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_vld_reg) |-> $past(s1_vld_reg))
        else $error("output word without an operate stage word");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_vld_reg && o_vld_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule
